[sv/cfpe_pkg.sv]
// Package for the capture fade and peak envelope block.
// Payload structs, register indexes, reset values and internal bundles.
// No dependencies.
package cfpe_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned TotalW  = 32;
  localparam int unsigned GainW   = 33;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [GainW-1:0] GainOne = {1'b1, 32'h0};

  localparam logic [CfgIdxW-1:0] RegSkipSamples    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFadeSamples    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegFadeStep       = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBucketSize     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegReportInterval = 3'd4;

  localparam logic [19:0] SkipSamplesRst    = 20'd19200;
  localparam logic [19:0] FadeSamplesRst    = 20'd14400;
  localparam logic [31:0] FadeStepRst       = 32'd298262;
  localparam logic [15:0] BucketSizeRst     = 16'd480;
  localparam logic [23:0] ReportIntervalRst = 24'd4800;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               restart;
  } cfpe_in_t;

  typedef struct packed {
    logic signed [15:0] faded_sample;
    logic               wave_valid;
    logic [7:0]         wave_peak;
    logic               level_valid;
    logic [15:0]        level_peak;
    logic [31:0]        samples_total;
  } cfpe_out_t;

  typedef struct packed {
    logic [19:0] skip_samples;
    logic [19:0] fade_samples;
    logic [31:0] fade_step;
    logic [15:0] bucket_size;
    logic [23:0] report_interval;
  } cfpe_cfg_t;

  typedef struct packed {
    logic [15:0] mag;
    logic [15:0] faded;
    logic [31:0] total;
  } cfpe_fade_t;

  typedef struct packed {
    logic        wave_valid;
    logic [7:0]  wave_peak;
    logic        level_valid;
    logic [15:0] level_peak;
  } cfpe_peak_t;

endpackage

[sv/capture_fade_peak_envelope.sv]
// Top level of the capture fade and peak envelope block.
// Depends on cfpe_pkg, cfpe_fade and cfpe_peak.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  cfpe_in_t
//   out      output     out_valid_o/out_stall_i cfpe_out_t
//   cfg      input      cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// One sample per cycle while the output is not stalled; a sample passes the input register, then the result register.
// The fade multiply and both peak updates sit in the single stage between them.
// Reset clears the position counter, gain, peaks and the valid flags;
// registers take their documented reset values.
// A stalled result holds; the input register still takes one transaction.
module capture_fade_peak_envelope (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  cfpe_pkg::cfpe_in_t      in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output cfpe_pkg::cfpe_out_t     out_data_o,
  input  logic                    cfg_we_i,
  input  logic [cfpe_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cfpe_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import cfpe_pkg::*;

  cfpe_cfg_t  cfg_q;
  cfpe_in_t   in_q;
  logic       in_valid_q;
  cfpe_out_t  out_q;
  logic       out_valid_q;
  logic       adv;
  logic       in_acc;
  cfpe_fade_t fade;
  cfpe_peak_t peak;

  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.skip_samples    <= SkipSamplesRst;
      cfg_q.fade_samples    <= FadeSamplesRst;
      cfg_q.fade_step       <= FadeStepRst;
      cfg_q.bucket_size     <= BucketSizeRst;
      cfg_q.report_interval <= ReportIntervalRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegSkipSamples:    cfg_q.skip_samples    <= cfg_wdata_i[19:0];
        RegFadeSamples:    cfg_q.fade_samples    <= cfg_wdata_i[19:0];
        RegFadeStep:       cfg_q.fade_step       <= cfg_wdata_i;
        RegBucketSize:     cfg_q.bucket_size     <= cfg_wdata_i[15:0];
        RegReportInterval: cfg_q.report_interval <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
    if (adv) begin
      out_q.faded_sample  <= fade.faded;
      out_q.wave_valid    <= peak.wave_valid;
      out_q.wave_peak     <= peak.wave_peak;
      out_q.level_valid   <= peak.level_valid;
      out_q.level_peak    <= peak.level_peak;
      out_q.samples_total <= fade.total;
    end
  end

  cfpe_fade u_fade (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .in_i   (in_q),
    .cfg_i  (cfg_q),
    .fade_o (fade)
  );

  cfpe_peak u_peak (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .restart_i (in_q.restart),
    .fade_i    (fade),
    .cfg_i     (cfg_q),
    .peak_o    (peak)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_adv_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_o)
    else $error("advanced transaction did not reach the result register");

  a_total_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_q.samples_total != 32'd0))
    else $error("sample total of a result is zero");

  a_wave_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_q.wave_peak <= 8'd128) &&
                    (out_q.wave_valid || (out_q.wave_peak == 8'd0)))
    else $error("wave peak out of range or set without a bucket");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_q.level_valid |-> (out_q.level_peak == 16'd0))
    else $error("level peak set without a report");

endmodule

[sv/cfpe_fade.sv]
// Skip zeroing and fade-in gain with the sample position counter.
// Depends on cfpe_pkg.
module cfpe_fade (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  cfpe_pkg::cfpe_in_t  in_i,
  input  cfpe_pkg::cfpe_cfg_t cfg_i,
  output cfpe_pkg::cfpe_fade_t fade_o
);
  import cfpe_pkg::*;

  logic [TotalW-1:0] idx_q, idx_d, idx;
  logic [GainW-1:0]  gain_q, gain_d, gain;
  logic              neg;
  logic [15:0]       raw, mag_in, mag;
  logic [47:0]       prod;
  logic [33:0]       gain_sum;
  logic [31:0]       fade_end;

  always_comb begin
    idx      = in_i.restart ? '0 : idx_q;
    gain     = in_i.restart ? '0 : gain_q;
    raw      = in_i.sample;
    neg      = raw[15];
    mag_in   = neg ? 16'(16'd0 - raw) : raw;
    prod     = 48'(mag_in) * 48'(gain) + 48'h0000_8000_0000;
    gain_sum = 34'(gain) + 34'(cfg_i.fade_step);
    fade_end = 32'(cfg_i.skip_samples) + 32'(cfg_i.fade_samples);
    gain_d   = gain;
    if (idx < 32'(cfg_i.skip_samples)) begin
      mag = '0;
    end else if (idx < fade_end) begin
      mag    = prod[47:32];
      gain_d = (gain_sum > 34'(GainOne)) ? GainOne : gain_sum[GainW-1:0];
    end else begin
      mag = mag_in;
    end
    idx_d        = (idx == '1) ? idx : idx + 32'd1;
    fade_o.mag   = mag;
    fade_o.faded = neg ? 16'(16'd0 - mag) : mag;
    fade_o.total = idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      gain_q <= '0;
    end else if (adv_i) begin
      idx_q  <= idx_d;
      gain_q <= gain_d;
    end
  end

endmodule

[sv/cfpe_peak.sv]
// Waveform bucket peak holder and level report peak holder.
// Depends on cfpe_pkg.
module cfpe_peak (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 restart_i,
  input  cfpe_pkg::cfpe_fade_t fade_i,
  input  cfpe_pkg::cfpe_cfg_t  cfg_i,
  output cfpe_pkg::cfpe_peak_t peak_o
);
  import cfpe_pkg::*;

  logic [15:0] bcnt_q, bcnt_d, bcnt;
  logic [15:0] bpeak_q, bpeak_d, bpeak;
  logic [15:0] lmax_q, lmax_d, lmax;
  logic [31:0] lrep_q, lrep_d, lrep;
  logic [16:0] cnt;
  logic [31:0] diff;

  always_comb begin
    bcnt  = restart_i ? '0 : bcnt_q;
    bpeak = restart_i ? '0 : bpeak_q;
    lmax  = restart_i ? '0 : lmax_q;
    lrep  = restart_i ? '0 : lrep_q;

    peak_o  = '0;
    bpeak_d = (bpeak < fade_i.mag) ? fade_i.mag : bpeak;
    cnt     = 17'(bcnt) + 17'd1;
    bcnt_d  = cnt[15:0];
    if (cnt >= 17'(cfg_i.bucket_size)) begin
      peak_o.wave_valid = 1'b1;
      peak_o.wave_peak  = bpeak_d[15:8];
      bpeak_d           = '0;
      bcnt_d            = '0;
    end

    lmax_d = (lmax < fade_i.mag) ? fade_i.mag : lmax;
    lrep_d = lrep;
    diff   = fade_i.total - lrep;
    if ((fade_i.total >= lrep) && (diff > 32'(cfg_i.report_interval))) begin
      peak_o.level_valid = 1'b1;
      peak_o.level_peak  = lmax_d;
      lrep_d             = fade_i.total;
      lmax_d             = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcnt_q  <= '0;
      bpeak_q <= '0;
      lmax_q  <= '0;
      lrep_q  <= '0;
    end else if (adv_i) begin
      bcnt_q  <= bcnt_d;
      bpeak_q <= bpeak_d;
      lmax_q  <= lmax_d;
      lrep_q  <= lrep_d;
    end
  end

endmodule
